>>> rtl/core/kpe_pkg.sv
// package: shared types, constants and the key table for the keypad number entry block
`default_nettype none

package kpe_pkg;

    // configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_DEBOUNCE_ADDR = 3'd0;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd100;

    // defaults for top level parameters
    localparam int unsigned MAX_DIGITS_DEFAULT = 4;
    localparam int unsigned MID_DEPTH_DEFAULT  = 2;
    localparam int unsigned OUT_DEPTH_DEFAULT  = 2;

    // special keys
    localparam logic [7:0] KEY_CANCEL  = 8'h63; // 'c'
    localparam logic [7:0] KEY_DELETE  = 8'h2b; // '+'
    localparam logic [7:0] KEY_CONFIRM = 8'h3d; // '='
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_NINE  = 8'h39;

    localparam logic [3:0] COLS_RELEASED = 4'hf;

    // keypad layout, index is {row, col}
    localparam logic [7:0] KEY_TABLE [0:15] = '{
        8'h37, 8'h38, 8'h39, 8'h2f,   // 7 8 9 /
        8'h34, 8'h35, 8'h36, 8'h2a,   // 4 5 6 *
        8'h31, 8'h32, 8'h33, 8'h2d,   // 1 2 3 -
        8'h63, 8'h30, 8'h3d, 8'h2b    // c 0 = +
    };

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SCAN,
        PH_RELEASE,
        PH_DEBOUNCE
    } phase_t;

    typedef enum logic [2:0] {
        KIND_OTHER,
        KIND_DIGIT,
        KIND_DELETE,
        KIND_CONFIRM,
        KIND_CANCEL
    } key_kind_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_APPEND,
        ACT_REMOVE,
        ACT_CONFIRM,
        ACT_CANCEL,
        ACT_IGNORED
    } action_t;

    // word from scanner to entry stage
    typedef struct packed {
        logic [3:0] rows;
        logic       fire;
        logic [7:0] key;
        key_kind_t  kind;
        logic [3:0] digit;
    } kpe_cmd_t;

    // result word
    typedef struct packed {
        logic [3:0]  row_drive;
        logic        key_valid;
        logic [7:0]  key_code;
        action_t     action;
        logic [13:0] entry_value;
        logic [2:0]  digit_count;
    } kpe_res_t;

    function automatic key_kind_t classify_key(input logic [7:0] key);
        key_kind_t kind;
        if (key == KEY_CANCEL)
            kind = KIND_CANCEL;
        else if (key >= ASCII_ZERO && key <= ASCII_NINE)
            kind = KIND_DIGIT;
        else if (key == KEY_DELETE)
            kind = KIND_DELETE;
        else if (key == KEY_CONFIRM)
            kind = KIND_CONFIRM;
        else
            kind = KIND_OTHER;
        return kind;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/kpe_fifo.sv
// small flop-based queue, depth a power of two
`default_nettype none

module kpe_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = CW'(count_reg + 1'b1);
        else if (do_pop && !do_push)
            count_next = CW'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

>>> rtl/core/kpe_scan.sv
// front stage: row scan, release wait and debounce, classifies the captured key
`default_nettype none

module kpe_scan
    import kpe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        take,
    input  wire logic [3:0]  col_lines,
    input  wire logic [15:0] debounce_ticks,
    output kpe_cmd_t         cmd
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  scan_row_reg, scan_row_next;
    logic [7:0]  pending_key_reg, pending_key_next;
    logic [15:0] debounce_count_reg, debounce_count_next;
    logic [15:0] count_dec;
    logic [1:0]  low_col;
    logic [1:0]  row_inc;
    logic [3:0]  rows;
    logic        fire;

    // lowest low column, column 3 when the first three are high
    always_comb
    begin
        if (!col_lines[0])
            low_col = 2'd0;
        else if (!col_lines[1])
            low_col = 2'd1;
        else if (!col_lines[2])
            low_col = 2'd2;
        else
            low_col = 2'd3;
    end

    assign row_inc   = 2'(scan_row_reg + 1'b1);
    assign count_dec = (debounce_count_reg != '0) ? 16'(debounce_count_reg - 1'b1) : '0;

    always_comb
    begin
        phase_next          = phase_reg;
        scan_row_next       = scan_row_reg;
        pending_key_next    = pending_key_reg;
        debounce_count_next = debounce_count_reg;
        rows                = '0;
        fire                = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (col_lines != COLS_RELEASED)
                begin
                    phase_next    = PH_SCAN;
                    scan_row_next = '0;
                    rows          = 4'he;
                end
            end
            PH_SCAN:
            begin
                if (col_lines != COLS_RELEASED)
                begin
                    pending_key_next = KEY_TABLE[{scan_row_reg, low_col}];
                    phase_next       = PH_RELEASE;
                end
                else if (scan_row_reg == 2'd3)
                begin
                    phase_next    = PH_IDLE;
                    scan_row_next = '0;
                end
                else
                begin
                    scan_row_next = row_inc;
                    rows          = 4'(~(4'b0001 << row_inc));
                end
            end
            PH_RELEASE:
            begin
                if (col_lines == COLS_RELEASED)
                begin
                    debounce_count_next = debounce_ticks;
                    if (debounce_ticks == '0)
                        fire = 1'b1;
                    else
                        phase_next = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE:
            begin
                debounce_count_next = count_dec;
                if (count_dec == '0)
                    fire = 1'b1;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (fire)
        begin
            phase_next    = PH_IDLE;
            scan_row_next = '0;
        end
    end

    always_comb
    begin
        cmd.rows  = rows;
        cmd.fire  = fire;
        cmd.key   = pending_key_next;
        cmd.kind  = classify_key(pending_key_next);
        cmd.digit = 4'(pending_key_next - ASCII_ZERO);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            scan_row_reg       <= '0;
            pending_key_reg    <= '0;
            debounce_count_reg <= '0;
        end
        else if (take)
        begin
            phase_reg          <= phase_next;
            scan_row_reg       <= scan_row_next;
            pending_key_reg    <= pending_key_next;
            debounce_count_reg <= debounce_count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/kpe_entry.sv
// back stage: applies debounced keys to the number entry and builds result words
`default_nettype none

module kpe_entry
    import kpe_pkg::*;
#(
    parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire kpe_cmd_t cmd,
    input  wire logic     cmd_empty,
    output logic          cmd_pop,
    input  wire logic     res_full,
    output logic          res_push,
    output kpe_res_t      res
);

    logic [13:0] entered_value_reg, entered_value_next;
    logic [2:0]  entered_digits_reg, entered_digits_next;
    logic        go;
    logic [17:0] times_ten;
    logic [29:0] recip_prod;
    logic [13:0] appended;
    logic [13:0] removed;
    logic [13:0] shown;
    action_t     act;

    assign go       = !cmd_empty && !res_full;
    assign cmd_pop  = go;
    assign res_push = go;

    // v*10 + d, kept to 14 bits
    assign times_ten  = {1'b0, entered_value_reg, 3'b000} + {3'b000, entered_value_reg, 1'b0}
                        + {14'd0, cmd.digit};
    assign appended   = times_ten[13:0];
    // v/10 via reciprocal, exact for every 14-bit v
    assign recip_prod = entered_value_reg * 16'd52429;
    assign removed    = {3'b000, recip_prod[29:19]};

    always_comb
    begin
        entered_value_next  = entered_value_reg;
        entered_digits_next = entered_digits_reg;
        shown               = entered_value_reg;
        act                 = ACT_NONE;

        if (cmd.fire)
        begin
            unique case (cmd.kind)
                KIND_CANCEL:
                begin
                    entered_value_next  = '0;
                    entered_digits_next = '0;
                    shown               = '0;
                    act                 = ACT_CANCEL;
                end
                KIND_DIGIT:
                begin
                    if (entered_digits_reg < 3'(MAX_DIGITS))
                    begin
                        entered_value_next  = appended;
                        entered_digits_next = 3'(entered_digits_reg + 1'b1);
                        shown               = appended;
                        act                 = ACT_APPEND;
                    end
                    else
                        act = ACT_IGNORED;
                end
                KIND_DELETE:
                begin
                    if (entered_digits_reg != '0)
                    begin
                        entered_value_next  = removed;
                        entered_digits_next = 3'(entered_digits_reg - 1'b1);
                        shown               = removed;
                        act                 = ACT_REMOVE;
                    end
                    else
                        act = ACT_IGNORED;
                end
                KIND_CONFIRM:
                begin
                    entered_value_next  = '0;
                    entered_digits_next = '0;
                    act                 = ACT_CONFIRM;
                end
                default:
                begin
                    act = ACT_IGNORED;
                end
            endcase
        end
    end

    always_comb
    begin
        res.row_drive   = cmd.rows;
        res.key_valid   = cmd.fire;
        res.key_code    = cmd.fire ? cmd.key : '0;
        res.action      = act;
        res.entry_value = shown;
        res.digit_count = entered_digits_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entered_value_reg  <= '0;
            entered_digits_reg <= '0;
        end
        else if (go)
        begin
            entered_value_reg  <= entered_value_next;
            entered_digits_reg <= entered_digits_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/keypad_scan_number_entry.sv
// top level: 4x4 keypad scanner with decimal number entry
//
// each input word is one tick of sampled column lines (active low); each accepted word
// yields exactly one result word carrying the row levels for the next tick, the key that
// took effect (if any), the entry action, the running value and the digit count. the
// block sustains one word per clock while full is low: the scanner stage decides the row
// pattern and debounce in the cycle the word is pushed, and writes a command word into a
// queue (two entries by default); the entry stage pulls from that queue and writes the
// result into a second queue (two entries by default) whose head drives the result ports.
// a result is registered in the command queue and then in the result queue before it is
// visible on the result ports. full rises only after the result queue has filled up,
// which happens only when results are not being popped. debounce_ticks is set through
// the apb port at byte address 0 (reset 100) and should only be written while the block
// has no words in flight.
`default_nettype none

module keypad_scan_number_entry
    import kpe_pkg::*;
#(
    parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEFAULT,
    parameter int unsigned MID_DEPTH  = MID_DEPTH_DEFAULT,
    parameter int unsigned OUT_DEPTH  = OUT_DEPTH_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,

    // input words
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [3:0]            col_lines,

    // result words
    output logic                       empty,
    input  wire logic                  pop,
    output logic [3:0]                 row_drive,
    output logic                       key_valid,
    output logic [7:0]                 key_code,
    output logic [2:0]                 action,
    output logic [13:0]                entry_value,
    output logic [2:0]                 digit_count
);

    logic [15:0] debounce_ticks_reg;
    logic        cfg_write;
    logic        take;
    logic        mid_full, mid_empty, mid_pop;
    logic        out_full, res_push;
    kpe_cmd_t    scan_cmd, mid_cmd;
    kpe_res_t    res_in, res_head;

    // register file: single debounce register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == REG_DEBOUNCE_ADDR);
    assign prdata    = (paddr == REG_DEBOUNCE_ADDR) ? {16'd0, debounce_ticks_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            debounce_ticks_reg <= DEBOUNCE_RESET;
        else if (cfg_write)
            debounce_ticks_reg <= pwdata[15:0];
    end

    // scanner takes a word whenever the middle queue has room
    assign full = mid_full;
    assign take = push && !mid_full;

    kpe_scan u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .col_lines      (col_lines),
        .debounce_ticks (debounce_ticks_reg),
        .cmd            (scan_cmd)
    );

    kpe_fifo #(
        .WIDTH ($bits(kpe_cmd_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (take),
        .wdata (scan_cmd),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_cmd),
        .empty (mid_empty)
    );

    kpe_entry #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_entry (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (mid_cmd),
        .cmd_empty (mid_empty),
        .cmd_pop   (mid_pop),
        .res_full  (out_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // result queue, head drives the ports
    kpe_fifo #(
        .WIDTH ($bits(kpe_res_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (out_full),
        .pop   (pop),
        .rdata (res_head),
        .empty (empty)
    );

    assign row_drive   = res_head.row_drive;
    assign key_valid   = res_head.key_valid;
    assign key_code    = res_head.key_code;
    assign action      = res_head.action;
    assign entry_value = res_head.entry_value;
    assign digit_count = res_head.digit_count;

endmodule

`default_nettype wire
